// ----- hw/rtl/fmd_pkg.sv -----
// Shared types, constants and helper functions of the binary32 multiply/divide unit.
`default_nettype none
package fmd_pkg;

  localparam int unsigned DivStages = 7;
  localparam int unsigned StepsPerStage = 4;
  localparam logic [31:0] CanonNan = 32'h7fc00000;
  localparam logic [30:0] InfMag = 31'h7f800000;
  localparam logic [7:0] ExpMax = 8'hff;
  localparam logic OpMul = 1'b0;
  localparam logic OpDiv = 1'b1;

  typedef struct packed {
    logic              special;
    logic [31:0]       spec_val;
    logic              op;
    logic              sign;
    logic signed [9:0] ea;
    logic signed [9:0] eb;
    logic [23:0]       ma;
    logic [23:0]       mb;
  } dec_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        spec_val;
    logic               op;
    logic               sign;
    logic signed [10:0] e;
    logic [23:0]        mb;
    logic [23:0]        rem;
    logic [31:0]        quo;
    logic [47:0]        prod;
  } work_t;

  typedef struct packed {
    logic signed [9:0] e;
    logic [23:0]       m;
  } sig_t;

  // One restoring division step: returns the quotient bit and the new remainder.
  function automatic logic [24:0] div_step(input logic [24:0] r, input logic [23:0] d);
    logic [24:0] diff;
    diff = r - {1'b0, d};
    if (r >= {1'b0, d}) begin
      return {1'b1, diff[23:0]};
    end
    return {1'b0, r[23:0]};
  endfunction

  // Exponent and significand with explicit leading one; subnormals are normalized.
  function automatic sig_t split_operand(input logic [7:0] ex, input logic [22:0] fr);
    sig_t res;
    logic [4:0] pos;
    logic [4:0] sh;
    pos = '0;
    if (ex != 8'd0) begin
      res.e = {2'b00, ex};
      res.m = {1'b1, fr};
    end else begin
      for (int i = 0; i < 23; i++) begin
        if (fr[i]) begin
          pos = 5'(i);
        end
      end
      sh = 5'd23 - pos;
      res.m = {1'b0, fr} << sh;
      res.e = 10'sd1 - $signed({5'b00000, sh});
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fmd_if.sv -----
// Valid/ready channel interfaces for operation requests and results.
`default_nettype none
interface fmd_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, output action, output operand_a, output operand_b, input ready);
  modport sink (input valid, input action, input operand_a, input operand_b, output ready);
endinterface

interface fmd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fmd_unpack.sv -----
// Operand decode, special cases, product and first quotient bits.
`default_nettype none
module fmd_unpack (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic          action_i,
  input  wire logic [31:0]   operand_a_i,
  input  wire logic [31:0]   operand_b_i,
  output logic               valid_o,
  output fmd_pkg::work_t     work_o
);

  fmd_pkg::dec_t  dec_d, dec_q;
  fmd_pkg::work_t work_d, work_q;
  fmd_pkg::sig_t  sa, sb;
  logic           valid_a_q, valid_b_q;
  logic [7:0]     ea_raw, eb_raw;
  logic           za, zb, na, nb, s;
  logic [24:0]    stp;
  logic [23:0]    r;
  logic [3:0]     qb;

  always_comb begin
    ea_raw = operand_a_i[30:23];
    eb_raw = operand_b_i[30:23];
    za = operand_a_i[30:0] == 31'd0;
    zb = operand_b_i[30:0] == 31'd0;
    na = (ea_raw == fmd_pkg::ExpMax) && (operand_a_i[22:0] != 23'd0);
    nb = (eb_raw == fmd_pkg::ExpMax) && (operand_b_i[22:0] != 23'd0);
    s = operand_a_i[31] ^ operand_b_i[31];
    sa = fmd_pkg::split_operand(ea_raw, operand_a_i[22:0]);
    sb = fmd_pkg::split_operand(eb_raw, operand_b_i[22:0]);
    dec_d.op = action_i;
    dec_d.sign = s;
    dec_d.ea = sa.e;
    dec_d.eb = sb.e;
    dec_d.ma = sa.m;
    dec_d.mb = sb.m;
    dec_d.special = 1'b0;
    dec_d.spec_val = {s, 31'd0};
    if (action_i == fmd_pkg::OpMul) begin
      if (ea_raw == fmd_pkg::ExpMax || eb_raw == fmd_pkg::ExpMax) begin
        dec_d.special = 1'b1;
        dec_d.spec_val = (na || nb || za || zb) ? fmd_pkg::CanonNan : {s, fmd_pkg::InfMag};
      end else if (za || zb) begin
        dec_d.special = 1'b1;
      end
    end else begin
      if (ea_raw == fmd_pkg::ExpMax || eb_raw == fmd_pkg::ExpMax) begin
        dec_d.special = 1'b1;
        if (na || nb || (ea_raw == fmd_pkg::ExpMax && eb_raw == fmd_pkg::ExpMax)) begin
          dec_d.spec_val = fmd_pkg::CanonNan;
        end else if (ea_raw == fmd_pkg::ExpMax) begin
          dec_d.spec_val = {s, fmd_pkg::InfMag};
        end
      end else if (zb) begin
        dec_d.special = 1'b1;
        dec_d.spec_val = za ? fmd_pkg::CanonNan : {s, fmd_pkg::InfMag};
      end else if (za) begin
        dec_d.special = 1'b1;
      end
    end
  end

  always_comb begin
    stp = fmd_pkg::div_step({1'b0, dec_q.ma}, dec_q.mb);
    qb[3] = stp[24];
    r = stp[23:0];
    for (int i = 2; i >= 0; i--) begin
      stp = fmd_pkg::div_step({r, 1'b0}, dec_q.mb);
      qb[i] = stp[24];
      r = stp[23:0];
    end
    work_d.special = dec_q.special;
    work_d.spec_val = dec_q.spec_val;
    work_d.op = dec_q.op;
    work_d.sign = dec_q.sign;
    work_d.e = (dec_q.op == fmd_pkg::OpDiv) ?
               (11'(dec_q.ea) - 11'(dec_q.eb)) : (11'(dec_q.ea) + 11'(dec_q.eb));
    work_d.mb = dec_q.mb;
    work_d.rem = r;
    work_d.quo = {28'd0, qb};
    work_d.prod = 48'(dec_q.ma) * 48'(dec_q.mb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
      work_q <= work_d;
    end
  end

  assign valid_o = valid_b_q;
  assign work_o = work_q;

endmodule
`default_nettype wire

// ----- hw/rtl/fmd_div_stage.sv -----
// One pipeline stage of the restoring divider, four quotient bits per stage.
`default_nettype none
module fmd_div_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire fmd_pkg::work_t work_i,
  output logic                valid_o,
  output fmd_pkg::work_t      work_o
);

  fmd_pkg::work_t work_d, work_q;
  logic           valid_q;
  logic [24:0]    stp;
  logic [23:0]    r;
  logic [3:0]     qb;

  always_comb begin
    r = work_i.rem;
    qb = '0;
    for (int i = fmd_pkg::StepsPerStage - 1; i >= 0; i--) begin
      stp = fmd_pkg::div_step({r, 1'b0}, work_i.mb);
      qb[i] = stp[24];
      r = stp[23:0];
    end
    work_d = work_i;
    work_d.rem = r;
    work_d.quo = {work_i.quo[27:0], qb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o = work_q;

endmodule
`default_nettype wire

// ----- hw/rtl/fmd_round.sv -----
// Significand alignment, round-to-nearest-even and result packing.
`default_nettype none
module fmd_round (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire fmd_pkg::work_t work_i,
  output logic                valid_o,
  output logic [31:0]         result_o
);

  logic               n_valid_q, o_valid_q;
  logic               n_special_q, n_sign_q;
  logic [31:0]        n_spec_q;
  logic signed [10:0] n_e_d, n_e_q, e1, shs;
  logic [47:0]        n_m_d, n_m_q;
  logic [5:0]         sh;
  logic [63:0]        mask, half;
  logic [47:0]        rest, shifted;
  logic [23:0]        f;
  logic [24:0]        f25;
  logic               inc;
  logic [31:0]        res_d, res_q;

  always_comb begin
    if (work_i.op == fmd_pkg::OpMul) begin
      if (work_i.prod[47]) begin
        n_m_d = work_i.prod;
        n_e_d = work_i.e - 11'sd126;
      end else begin
        n_m_d = {work_i.prod[46:0], 1'b0};
        n_e_d = work_i.e - 11'sd127;
      end
    end else begin
      if (work_i.quo[31]) begin
        n_m_d = {work_i.quo, 16'd0};
        n_e_d = work_i.e + 11'sd127;
      end else begin
        n_m_d = {work_i.quo[30:0], 17'd0};
        n_e_d = work_i.e + 11'sd126;
      end
      n_m_d[0] = n_m_d[0] | (work_i.rem != 24'd0);
    end
  end

  always_comb begin
    shs = 11'sd25 - n_e_q;
    if (n_e_q > 11'sd0) begin
      sh = 6'd24;
    end else if (shs > 11'sd50) begin
      sh = 6'd50;
    end else begin
      sh = shs[5:0];
    end
    mask = (64'd1 << sh) - 64'd1;
    half = 64'd1 << (sh - 6'd1);
    rest = n_m_q & mask[47:0];
    shifted = n_m_q >> sh;
    f = shifted[23:0];
    inc = ({16'd0, rest} > half) || (({16'd0, rest} == half) && f[0]);
    f25 = {1'b0, f} + {24'd0, inc};
    e1 = n_e_q + 11'sd1;
    if (n_special_q) begin
      res_d = n_spec_q;
    end else if (n_e_q >= 11'sd255) begin
      res_d = {n_sign_q, fmd_pkg::InfMag};
    end else if (n_e_q <= 11'sd0) begin
      res_d = {n_sign_q, 6'd0, f25};
    end else if (f25[24]) begin
      res_d = (e1 >= 11'sd255) ? {n_sign_q, fmd_pkg::InfMag} : {n_sign_q, e1[7:0], 23'd0};
    end else begin
      res_d = {n_sign_q, n_e_q[7:0], f25[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en_i) begin
      n_valid_q <= valid_i;
      o_valid_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_special_q <= work_i.special;
      n_spec_q <= work_i.spec_val;
      n_sign_q <= work_i.sign;
      n_e_q <= n_e_d;
      n_m_q <= n_m_d;
      res_q <= res_d;
    end
  end

  assign valid_o = o_valid_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// ----- hw/rtl/float32_mul_div_unit.sv -----
// Top level of the pipelined binary32 multiply/divide unit.
// Usage: a request transaction on req_i carries action (0 multiply, 1 divide a by b)
// and two binary32 bit patterns; each request yields exactly one response
// transaction on rsp_o carrying the rounded result, in request order.
// Rounding is round-to-nearest-even; any NaN result is the quiet NaN 0x7fc00000.
// On its way to the response, a request passes an operand decode stage, a stage
// that holds the 24x24 multiplier and the first four quotient bits, seven
// divider stages of four quotient bits each, an alignment stage and a
// rounding stage whose register drives rsp_o.
// Throughput is one transaction per cycle for any mix of operations while rsp_o is not stalled.
// Reset clears all valid bits, so the pipeline comes up empty.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_i.ready drops; bubbles in the pipeline stay where they are until it resumes.
`default_nettype none
module float32_mul_div_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fmd_req_if.sink    req_i,
  fmd_rsp_if.source  rsp_o
);

  logic           en;
  logic           out_valid;
  logic           st_valid [fmd_pkg::DivStages + 1];
  fmd_pkg::work_t st_work  [fmd_pkg::DivStages + 1];

  assign en = !out_valid || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = out_valid;

  fmd_unpack u_unpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (req_i.valid),
    .action_i   (req_i.action),
    .operand_a_i(req_i.operand_a),
    .operand_b_i(req_i.operand_b),
    .valid_o    (st_valid[0]),
    .work_o     (st_work[0])
  );

  for (genvar g = 0; g < fmd_pkg::DivStages; g++) begin : g_div
    fmd_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(st_valid[g]),
      .work_i (st_work[g]),
      .valid_o(st_valid[g + 1]),
      .work_o (st_work[g + 1])
    );
  end

  fmd_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st_valid[fmd_pkg::DivStages]),
    .work_i  (st_work[fmd_pkg::DivStages]),
    .valid_o (out_valid),
    .result_o(rsp_o.result)
  );

endmodule
`default_nettype wire
